// ===== sv/pfdm_pkg.sv =====
// Shared types and constants for the PWM frequency and duty meter.
// Used by every module of the meter; depends on nothing else.
package pfdm_pkg;

   // Width of the phase tick counters.
   localparam int COUNT_WIDTH = 32;
   localparam int CLOCK_HZ_W = 28;
   localparam int OUT_COUNT_W = 32;
   localparam int FREQ_W = 16;
   localparam int DUTY_W = 7;

   localparam int PERIOD_W = COUNT_WIDTH + 1;
   localparam int PROD_W = COUNT_WIDTH + DUTY_W;
   localparam int DIV_NUM_W = (PROD_W > CLOCK_HZ_W) ? PROD_W : CLOCK_HZ_W;
   localparam int DIV_STEP_W = $clog2(DIV_NUM_W);

   localparam logic [CLOCK_HZ_W-1:0] CLOCK_HZ_RESET = CLOCK_HZ_W'(8000000);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_MAX = '1;
   localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
   localparam logic [DUTY_W-1:0] DUTY_SCALE = DUTY_W'(100);

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

   // One completed pair of phase lengths.
   typedef struct packed {
      logic [COUNT_WIDTH-1:0] high;
      logic [COUNT_WIDTH-1:0] low;
   } measurement_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic                   start;
      logic [DIV_NUM_W-1:0]   numerator;
      logic [PERIOD_W-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CALC,
      BK_FREQ_START,
      BK_FREQ_WAIT,
      BK_DUTY_START,
      BK_DUTY_WAIT,
      BK_DELIVER
   } back_state_type;

   // Saturates a tick count to the width of the result fields.
   function automatic logic [OUT_COUNT_W-1:0] clip_count(input logic [COUNT_WIDTH-1:0] v);
      logic [OUT_COUNT_W-1:0] r;
      if (v > COUNT_WIDTH'(OUT_COUNT_MAX)) begin
         r = OUT_COUNT_MAX;
      end else begin
         r = OUT_COUNT_W'(v);
      end
      return r;
   endfunction

endpackage

// ===== sv/pfdm_front.sv =====
// Front end of the PWM meter: edge detection and phase tick counting.
// Depends on pfdm_pkg; pushes finished high/low pairs into pfdm_queue.
module pfdm_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_pin_level,
   input  pfdm_pkg::queue_status_type  q_status,
   output logic                        push,
   output pfdm_pkg::measurement_type   push_data
);
   import pfdm_pkg::*;

   logic                   armed_ff, armed_in;
   logic                   prev_ff, prev_in;
   logic                   have_high_ff, have_high_in;
   logic                   have_low_ff, have_low_in;
   logic [COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic [COUNT_WIDTH-1:0] high_ff, high_in;
   logic [COUNT_WIDTH-1:0] low_ff, low_in;
   logic                   accept;
   logic                   rising;
   logic                   falling;

   // Input is held off only while the queue has no room for a result.
   assign req_stall = q_status.full;

   always_comb begin
      accept       = req_valid & ~q_status.full;
      rising       = req_pin_level & ~prev_ff;
      falling      = ~req_pin_level & prev_ff;
      armed_in     = armed_ff;
      prev_in      = prev_ff;
      have_high_in = have_high_ff;
      have_low_in  = have_low_ff;
      tick_in      = tick_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      if (accept) begin
         prev_in = req_pin_level;
         if (!armed_ff) begin
            if (rising) begin
               armed_in = 1'b1;
               tick_in  = COUNT_WIDTH'(1);
            end
         end else begin
            priority if (falling) begin
               high_in      = tick_ff;
               have_high_in = 1'b1;
               tick_in      = COUNT_WIDTH'(1);
            end else if (rising) begin
               low_in      = tick_ff;
               have_low_in = 1'b1;
               tick_in     = COUNT_WIDTH'(1);
            end else if (tick_ff < COUNT_MAX) begin
               tick_in = tick_ff + COUNT_WIDTH'(1);
            end
         end
      end
      push           = accept & armed_ff & (rising | falling) & have_high_in & have_low_in;
      push_data.high = high_in;
      push_data.low  = low_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= 1'b0;
         prev_ff      <= 1'b0;
         have_high_ff <= 1'b0;
         have_low_ff  <= 1'b0;
         tick_ff      <= '0;
         high_ff      <= '0;
         low_ff       <= '0;
      end else begin
         armed_ff     <= armed_in;
         prev_ff      <= prev_in;
         have_high_ff <= have_high_in;
         have_low_ff  <= have_low_in;
         tick_ff      <= tick_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
      end
   end

endmodule

// ===== sv/pfdm_queue.sv =====
// Short queue of measured phase pairs between the front and back ends.
// Depends on pfdm_pkg.
module pfdm_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  pfdm_pkg::measurement_type   push_data,
   input  logic                        pop,
   output pfdm_pkg::measurement_type   head,
   output pfdm_pkg::queue_status_type  q_status
);
   import pfdm_pkg::*;

   measurement_type       entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff;
   logic [QUEUE_AW-1:0]   rd_ptr_ff;
   logic [QUEUE_CW-1:0]   count_ff;
   logic                  do_push;
   logic                  do_pop;

   assign q_status.full  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push & ~q_status.full;
   assign do_pop         = pop & ~q_status.empty;
   assign head           = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         end
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + QUEUE_CW'(1);
            2'b01:   count_ff <= count_ff - QUEUE_CW'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && q_status.full))
      else $error("queue pushed while full");
   assert property (@(posedge clock) disable iff (reset) !(pop && q_status.empty))
      else $error("queue popped while empty");

endmodule

// ===== sv/pfdm_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by the back end
// for frequency and duty. Depends on pfdm_pkg.
module pfdm_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  pfdm_pkg::div_req_type  div_req,
   output pfdm_pkg::div_rsp_type  div_rsp
);
   import pfdm_pkg::*;

   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [DIV_NUM_W-1:0]  num_ff, num_in;
   logic [PERIOD_W-1:0]   rem_ff, rem_in;
   logic [PERIOD_W-1:0]   den_ff, den_in;
   logic [PERIOD_W:0]     trial;
   logic [PERIOD_W:0]     diff;
   logic                  fits;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      // The numerator shifts out at the top while quotient bits enter below.
      trial   = {rem_ff, num_ff[DIV_NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = (trial >= {1'b0, den_ff});
      if (div_req.start) begin
         run_in  = 1'b1;
         step_in = '0;
         num_in  = div_req.numerator;
         rem_in  = '0;
         den_in  = div_req.divisor;
      end else if (run_ff) begin
         num_in  = {num_ff[DIV_NUM_W-2:0], fits};
         rem_in  = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
         step_in = step_ff + DIV_STEP_W'(1);
         if (step_ff == DIV_STEP_W'(DIV_NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
      div_rsp.done     = done_ff;
      div_rsp.quotient = num_ff;
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      step_ff <= step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

endmodule

// ===== sv/pfdm_back.sv =====
// Back end of the PWM meter: takes phase pairs from the queue, divides
// for frequency and duty, and holds the result register. Uses pfdm_pkg
// and pfdm_divider.
module pfdm_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [pfdm_pkg::CLOCK_HZ_W-1:0]     csr_wr_data,
   input  pfdm_pkg::queue_status_type          q_status,
   input  pfdm_pkg::measurement_type           head,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pfdm_pkg::FREQ_W-1:0]         rsp_freq_hz,
   output logic [pfdm_pkg::DUTY_W-1:0]         rsp_duty_percent,
   output logic [pfdm_pkg::OUT_COUNT_W-1:0]    rsp_high_count,
   output logic [pfdm_pkg::OUT_COUNT_W-1:0]    rsp_low_count,
   output logic                                rsp_freq_saturated
);
   import pfdm_pkg::*;

   back_state_type         state_ff, state_in;
   logic [CLOCK_HZ_W-1:0]  clock_hz_ff;
   logic [COUNT_WIDTH-1:0] high_ff, high_in;
   logic [COUNT_WIDTH-1:0] low_ff, low_in;
   logic [PERIOD_W-1:0]    period_ff, period_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [FREQ_W-1:0]      freq_ff, freq_in;
   logic                   sat_ff, sat_in;
   logic [DUTY_W-1:0]      duty_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   out_load;
   logic [FREQ_W-1:0]      out_freq_ff;
   logic [DUTY_W-1:0]      out_duty_ff;
   logic [OUT_COUNT_W-1:0] out_high_ff;
   logic [OUT_COUNT_W-1:0] out_low_ff;
   logic                   out_sat_ff;
   logic                   period_zero;
   div_req_type            div_req;
   div_rsp_type            div_rsp;

   pfdm_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign period_zero = (period_ff == '0);

   always_comb begin
      state_in          = state_ff;
      high_in           = high_ff;
      low_in            = low_ff;
      period_in         = period_ff;
      prod_in           = prod_ff;
      freq_in           = freq_ff;
      sat_in            = sat_ff;
      duty_in           = '0;
      pop               = 1'b0;
      out_load          = 1'b0;
      div_req.start     = 1'b0;
      div_req.numerator = DIV_NUM_W'(clock_hz_ff);
      div_req.divisor   = period_ff;
      out_valid_in      = out_valid_ff & rsp_stall;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               high_in  = head.high;
               low_in   = head.low;
               state_in = BK_CALC;
            end
         end
         BK_CALC: begin
            period_in = PERIOD_W'(high_ff) + PERIOD_W'(low_ff);
            prod_in   = PROD_W'(high_ff) * PROD_W'(DUTY_SCALE);
            state_in  = BK_FREQ_START;
         end
         BK_FREQ_START: begin
            div_req.start = 1'b1;
            state_in      = BK_FREQ_WAIT;
         end
         BK_FREQ_WAIT: begin
            if (div_rsp.done) begin
               priority if (period_zero) begin
                  freq_in = '0;
                  sat_in  = 1'b0;
               end else if (div_rsp.quotient > DIV_NUM_W'(FREQ_MAX)) begin
                  freq_in = FREQ_MAX;
                  sat_in  = 1'b1;
               end else begin
                  freq_in = div_rsp.quotient[FREQ_W-1:0];
                  sat_in  = 1'b0;
               end
               state_in = BK_DUTY_START;
            end
         end
         BK_DUTY_START: begin
            div_req.start     = 1'b1;
            div_req.numerator = DIV_NUM_W'(prod_ff);
            state_in          = BK_DUTY_WAIT;
         end
         BK_DUTY_WAIT: begin
            if (div_rsp.done) begin
               state_in = BK_DELIVER;
            end
         end
         BK_DELIVER: begin
            // The duty quotient stays in the divider until the slot frees.
            if (!out_valid_ff || !rsp_stall) begin
               out_load     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
      if (!period_zero) begin
         duty_in = div_rsp.quotient[DUTY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
         clock_hz_ff  <= CLOCK_HZ_RESET;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            clock_hz_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      high_ff   <= high_in;
      low_ff    <= low_in;
      period_ff <= period_in;
      prod_ff   <= prod_in;
      freq_ff   <= freq_in;
      sat_ff    <= sat_in;
      if (out_load) begin
         out_freq_ff <= freq_ff;
         out_duty_ff <= duty_in;
         out_high_ff <= clip_count(high_ff);
         out_low_ff  <= clip_count(low_ff);
         out_sat_ff  <= sat_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_freq_hz        = out_freq_ff;
   assign rsp_duty_percent   = out_duty_ff;
   assign rsp_high_count     = out_high_ff;
   assign rsp_low_count      = out_low_ff;
   assign rsp_freq_saturated = out_sat_ff;

endmodule

// ===== sv/pwm_frequency_duty_meter_unit.sv =====
// PWM frequency and duty meter, top level. Each result is computed by
// the bit-serial divider, run twice per result in the back end, after
// the transaction carrying the closing edge; a new phase pair is taken
// from the queue only once the last result is delivered. Throughput: one pin
// sample per cycle; the front stalls only when the four-entry queue is full.
// Reset: synchronous, clears all control state; clock_hz returns to 8000000.
module pwm_frequency_duty_meter_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [pfdm_pkg::CLOCK_HZ_W-1:0]     csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_pin_level,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pfdm_pkg::FREQ_W-1:0]         rsp_freq_hz,
   output logic [pfdm_pkg::DUTY_W-1:0]         rsp_duty_percent,
   output logic [pfdm_pkg::OUT_COUNT_W-1:0]    rsp_high_count,
   output logic [pfdm_pkg::OUT_COUNT_W-1:0]    rsp_low_count,
   output logic                                rsp_freq_saturated
);
   import pfdm_pkg::*;

   queue_status_type q_status;
   measurement_type  push_data;
   measurement_type  head;
   logic             push;
   logic             pop;

   pfdm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pin_level (req_pin_level),
      .q_status      (q_status),
      .push          (push),
      .push_data     (push_data)
   );

   pfdm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .q_status  (q_status)
   );

   pfdm_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .q_status           (q_status),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_freq_hz        (rsp_freq_hz),
      .rsp_duty_percent   (rsp_duty_percent),
      .rsp_high_count     (rsp_high_count),
      .rsp_low_count      (rsp_low_count),
      .rsp_freq_saturated (rsp_freq_saturated)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_freq_saturated |-> rsp_freq_hz == FREQ_MAX)
      else $error("saturation flag without a saturated frequency");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty_percent <= DUTY_SCALE)
      else $error("duty above one hundred percent");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_high_count != '0) && (rsp_low_count != '0))
      else $error("result with an empty phase");

endmodule
